### src/srel_pkg.sv
// Shared constants, level codes and the level mapping for the ratio classifier.
`default_nettype none

package srel_pkg;

    // Field widths
    localparam int RATIO_W  = 24;
    localparam int TIME_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int LEVEL_W  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Q1.16 unity weight and rounding term
    localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [15:0]         ROUND_HALF = 16'h8000;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = ONE_Q16;
    localparam logic [TIME_W-1:0]   STALE_RST  = 32'd30000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 8'd1;

    // Level thresholds, Q8.16
    localparam logic [RATIO_W-1:0] TH_GOOD      = 24'd52429;
    localparam logic [RATIO_W-1:0] TH_FAIR      = 24'd42599;
    localparam logic [RATIO_W-1:0] TH_MODERATE  = 24'd32768;
    localparam logic [RATIO_W-1:0] TH_POOR      = 24'd22938;
    localparam logic [RATIO_W-1:0] TH_VERY_POOR = 24'd13108;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_UNKNOWN   = 3'd0,
        LVL_GOOD      = 3'd1,
        LVL_FAIR      = 3'd2,
        LVL_MODERATE  = 3'd3,
        LVL_POOR      = 3'd4,
        LVL_VERY_POOR = 3'd5,
        LVL_EXTREME   = 3'd6
    } level_t;

    // Map a filtered ratio onto the six-step scale, best band first
    function automatic level_t level_of(input logic [RATIO_W-1:0] r);
        level_t lvl;
        priority if (r >= TH_GOOD)      lvl = LVL_GOOD;
        else if (r >= TH_FAIR)          lvl = LVL_FAIR;
        else if (r >= TH_MODERATE)      lvl = LVL_MODERATE;
        else if (r >= TH_POOR)          lvl = LVL_POOR;
        else if (r >= TH_VERY_POOR)     lvl = LVL_VERY_POOR;
        else                            lvl = LVL_EXTREME;
        return lvl;
    endfunction

endpackage

`default_nettype wire

### src/sensor_ratio_ema_level_classifier.sv
// Top level: gas-sensor ratio smoother, staleness check and air-quality classifier.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: ratio_in, sample_time_ms, now_ms
//          |           |                    | tuser: read_ok, sensor_ready
//  m_*     | out       | m_tvalid/m_tready  | tdata: level, ratio_out, age_ms,
//          |           |                    |        good_count, bad_count; tuser: stale
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (0 weight, 1 limit)
//
// Each accepted word is processed combinationally: the averaging multiplies, the age
// subtract and the limit compare all sit between the input port and the result register,
// so one word per clock is sustained while m_tready is high; the result appears in the next cycle.
// The result register holds while m_tready is low; a new word is taken in the same
// cycle the held result leaves. Reset clears the filter, counters and last good time
// and loads the register defaults. The configuration port is always ready.
`default_nettype none

module sensor_ratio_ema_level_classifier
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [23:0] ratio_in, [55:24] sample_time_ms, [87:56] now_ms
    input  wire logic [87:0]                        s_tdata,
    // [0] read_ok, [1] sensor_ready
    input  wire logic [1:0]                         s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [2:0] level, [26:3] ratio_out, [58:27] age_ms, [90:59] good_count,
    // [122:91] bad_count, [127:123] zero
    output logic [127:0]                            m_tdata,
    // [0] stale
    output logic [0:0]                              m_tuser,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [srel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srel_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int RW = srel_pkg::RATIO_W;
    localparam int TW = srel_pkg::TIME_W;

    // Configuration registers
    logic [srel_pkg::WEIGHT_W-1:0] weight_reg;
    logic [TW-1:0]                 limit_reg;

    // Filter and bookkeeping state
    logic          filt_valid_reg;
    logic          filt_valid_next;
    logic [RW-1:0] filt_ratio_reg;
    logic [RW-1:0] filt_ratio_next;
    logic [TW-1:0] last_good_reg;
    logic [TW-1:0] last_good_next;
    logic [TW-1:0] good_cnt_reg;
    logic [TW-1:0] good_cnt_next;
    logic [TW-1:0] bad_cnt_reg;
    logic [TW-1:0] bad_cnt_next;

    // Result register
    logic             out_valid_reg;
    srel_pkg::level_t level_reg;
    srel_pkg::level_t level_next;
    logic [RW-1:0]    ratio_out_reg;
    logic [TW-1:0]    age_reg;
    logic [TW-1:0]    age_next;
    logic             stale_reg;
    logic             stale_next;

    // Unpacked input word
    logic          read_ok;
    logic          sensor_ready;
    logic [RW-1:0] ratio_in;
    logic [TW-1:0] sample_time_ms;
    logic [TW-1:0] now_ms;

    logic          accept;
    logic          good_read;
    logic [RW-1:0] ratio_avg;
    logic [RW-1:0] ratio_cand;
    logic [TW-1:0] sample_age;

    assign read_ok        = s_tuser[0];
    assign sensor_ready   = s_tuser[1];
    assign ratio_in       = s_tdata[23:0];
    assign sample_time_ms = s_tdata[55:24];
    assign now_ms         = s_tdata[87:56];

    // Take a word whenever the result slot is free or draining this cycle
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign good_read = read_ok && sensor_ready;

    srel_ema u_ema
    (
        .weight    (weight_reg),
        .ratio_new (ratio_in),
        .ratio_old (filt_ratio_reg),
        .ratio_avg (ratio_avg)
    );

    // Age from the sample's own timestamp: unknown when never taken, zero if ahead
    always_comb
    begin
        if (sample_time_ms == '0)
        begin
            sample_age = '1;
        end
        else if (now_ms < sample_time_ms)
        begin
            sample_age = '0;
        end
        else
        begin
            sample_age = now_ms - sample_time_ms;
        end
    end

    always_comb
    begin
        good_cnt_next = good_cnt_reg + TW'(read_ok);
        bad_cnt_next  = bad_cnt_reg + TW'(!read_ok);

        if (good_read)
        begin
            last_good_next  = now_ms;
            age_next        = sample_age;
            filt_valid_next = 1'b1;
            ratio_cand      = filt_valid_reg ? ratio_avg : ratio_in;
        end
        else
        begin
            // Bad reading: age runs from the last good reading when there was one
            last_good_next  = last_good_reg;
            age_next        = (last_good_reg != '0) ? (now_ms - last_good_reg) : sample_age;
            filt_valid_next = 1'b0;
            ratio_cand      = '0;
        end

        filt_ratio_next = ratio_cand;
        stale_next      = 1'b0;
        level_next      = good_read ? srel_pkg::level_of(ratio_cand) : srel_pkg::LVL_UNKNOWN;

        if (last_good_next == '0)
        begin
            // Never a success: level unknown, stale flag left clear
            level_next = srel_pkg::LVL_UNKNOWN;
        end
        else if (age_next > limit_reg)
        begin
            // Stale: drop the filter and report unknown
            stale_next      = 1'b1;
            level_next      = srel_pkg::LVL_UNKNOWN;
            filt_valid_next = 1'b0;
            filt_ratio_next = '0;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= srel_pkg::WEIGHT_RST;
            limit_reg  <= srel_pkg::STALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == srel_pkg::REG_EMA_WEIGHT)
            begin
                weight_reg <= cfg_data[srel_pkg::WEIGHT_W-1:0];
            end
            else if (cfg_index == srel_pkg::REG_STALE_LIMIT)
            begin
                limit_reg <= cfg_data[TW-1:0];
            end
        end
    end

    // State advances once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_valid_reg <= 1'b0;
            filt_ratio_reg <= '0;
            last_good_reg  <= '0;
            good_cnt_reg   <= '0;
            bad_cnt_reg    <= '0;
        end
        else if (accept)
        begin
            filt_valid_reg <= filt_valid_next;
            filt_ratio_reg <= filt_ratio_next;
            last_good_reg  <= last_good_next;
            good_cnt_reg   <= good_cnt_next;
            bad_cnt_reg    <= bad_cnt_next;
        end
    end

    // Result valid: set on accept, clear when taken with nothing new behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg     <= level_next;
            ratio_out_reg <= filt_ratio_next;
            age_reg       <= age_next;
            stale_reg     <= stale_next;
        end
    end

    // good_count and bad_count read back from the live counters, which only move
    // on accept, i.e. together with the result payload
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, bad_cnt_reg, good_cnt_reg, age_reg, ratio_out_reg, level_reg};
    assign m_tuser  = stale_reg;

endmodule

`default_nettype wire

### src/srel_ema.sv
// Exponential averaging datapath: weighted blend of new and old ratio with rounding.
`default_nettype none

module srel_ema
(
    input  wire logic [srel_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [srel_pkg::RATIO_W-1:0]  ratio_new,
    input  wire logic [srel_pkg::RATIO_W-1:0]  ratio_old,
    output logic      [srel_pkg::RATIO_W-1:0]  ratio_avg
);

    localparam int PROD_W = srel_pkg::WEIGHT_W + srel_pkg::RATIO_W;
    localparam int ACC_W  = PROD_W + 1;

    logic [srel_pkg::WEIGHT_W-1:0] w_clip;
    logic [srel_pkg::WEIGHT_W-1:0] w_inv;
    logic [PROD_W-1:0]             prod_new;
    logic [PROD_W-1:0]             prod_old;
    logic [ACC_W-1:0]              acc;

    // Clamp weights above unity to unity
    assign w_clip   = (weight > srel_pkg::ONE_Q16) ? srel_pkg::ONE_Q16 : weight;
    assign w_inv    = srel_pkg::ONE_Q16 - w_clip;
    assign prod_new = PROD_W'(w_clip) * PROD_W'(ratio_new);
    assign prod_old = PROD_W'(w_inv) * PROD_W'(ratio_old);
    assign acc      = ACC_W'(prod_new) + ACC_W'(prod_old)
                    + ACC_W'(srel_pkg::ROUND_HALF);

    // Blend never exceeds the larger operand, so the top bits drop cleanly
    assign ratio_avg = acc[16 +: srel_pkg::RATIO_W];

endmodule

`default_nettype wire
